### src/assert_macros.svh
// Assertion macros for the rational arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RAR_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RAR_ASSERT(lbl, prop, msg)
`define RAR_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### src/rar_pkg.sv
// Shared types and constants for the rational arithmetic unit
package rar_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;
  localparam int unsigned FW = 32;
endpackage

### src/rar_front.sv
// Front end: request intake, cross products and raw fraction forming
module rar_front import rar_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [FW-1:0]    a_num_i,
  input  logic [FW-1:0]    a_den_i,
  input  logic [FW-1:0]    b_num_i,
  input  logic [FW-1:0]    b_den_i,
  output logic             raw_valid_o,
  input  logic             raw_ready_i,
  output logic [WIDTH-1:0] raw_num_o,
  output logic [WIDTH-1:0] raw_den_o
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [1:0]       cmd_q;
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic [WIDTH-1:0] p0_q, p1_q, den_q;
  logic [WIDTH-1:0] m0a, m0b, m1a, m1b, prod0, prod1, num_d;

  function automatic logic [WIDTH-1:0] ld(input logic [FW-1:0] v);
    logic [WIDTH+FW-1:0] e;
    e = {{WIDTH{v[FW-1]}}, v};
    return e[WIDTH-1:0];
  endfunction

  always_comb begin
    m0a = an_q; m0b = bd_q; m1a = bn_q; m1b = ad_q;
    if (st_q == ST_MUL1) begin
      case (cmd_q)
        CMD_MUL: begin m0b = bn_q; end
        default: begin end
      endcase
    end else begin
      m0a = ad_q; m0b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
    end
    prod0 = m0a * m0b;
    prod1 = m1a * m1b;
    case (cmd_q)
      CMD_ADD: num_d = p0_q + p1_q;
      CMD_SUB: num_d = p0_q - p1_q;
      default: num_d = p0_q;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_MUL1;
      ST_MUL1: st_d = ST_MUL2;
      ST_MUL2: st_d = ST_OUT;
      ST_OUT:  if (raw_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      cmd_q <= cmd_i;
      an_q <= ld(a_num_i); ad_q <= ld(a_den_i);
      bn_q <= ld(b_num_i); bd_q <= ld(b_den_i);
    end
    if (st_q == ST_MUL1) begin
      p0_q <= prod0; p1_q <= prod1;
    end
    if (st_q == ST_MUL2) begin
      den_q <= prod0;
      p0_q  <= num_d;
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign raw_valid_o = (st_q == ST_OUT);
  assign raw_num_o   = p0_q;
  assign raw_den_o   = den_q;
endmodule

### src/rar_fifo.sv
// Two-entry queue between front and back ends
module rar_fifo import rar_pkg::*; #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  `include "assert_macros.svh"
  `RAR_ASSERT(a_no_over, (cnt_q == 2'd2) |-> !wr, "queue overflow")
  `RAR_ASSERT(a_cnt_rng, cnt_q != 2'd3, "queue count out of range")
  `RAR_ASSERT(a_cnt_step, (wr && !rd) |=> (cnt_q == $past(cnt_q) + 2'd1), "count step")
endmodule

### src/rar_back.sv
// Back end: bit-serial GCD and exact division of the raw fraction
module rar_back import rar_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             raw_valid_i,
  output logic             raw_ready_o,
  input  logic [WIDTH-1:0] raw_num_i,
  input  logic [WIDTH-1:0] raw_den_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [WIDTH-1:0] res_num_o,
  output logic [WIDTH-1:0] res_den_o
);
  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_DIVN = 3'd2;
  localparam logic [2:0] ST_DIVD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]       st_q;
  logic [WIDTH-1:0] num_q, den_q;
  logic [WIDTH:0]   y_q, g_q;
  logic [WIDTH:0]   rem_q, quo_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH:0]   rsh, rsub, qn;
  logic [WIDTH:0]   mn, md;

  function automatic logic [WIDTH:0] mag(input logic [WIDTH-1:0] v);
    logic [WIDTH:0] e;
    e = {v[WIDTH-1], v};
    return v[WIDTH-1] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [WIDTH-1:0] sgn(input logic neg, input logic [WIDTH:0] q);
    logic [WIDTH:0] r;
    r = neg ? (~q + 1'b1) : q;
    return r[WIDTH-1:0];
  endfunction

  // restoring division step: rem/quo shift pair against divisor
  always_comb begin
    rsh  = {rem_q[WIDTH-1:0], quo_q[WIDTH]};
    rsub = rsh - ((st_q == ST_MOD) ? y_q : g_q);
    qn   = {quo_q[WIDTH-1:0], ~rsub[WIDTH]};
    if (rsh >= ((st_q == ST_MOD) ? y_q : g_q)) rsub = rsh - ((st_q == ST_MOD) ? y_q : g_q);
    else rsub = rsh;
    qn[0] = (rsh >= ((st_q == ST_MOD) ? y_q : g_q));
    mn = mag(num_q);
    md = mag(den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (raw_valid_i) begin
            if (raw_num_i == '0 || raw_den_i == '0) st_q <= ST_OUT;
            else st_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (cnt_q == CW'(WIDTH) && rsub == '0) st_q <= ST_DIVN;
        end
        ST_DIVN: if (cnt_q == CW'(WIDTH)) st_q <= ST_DIVD;
        ST_DIVD: if (cnt_q == CW'(WIDTH)) st_q <= ST_OUT;
        ST_OUT:  if (res_ready_i) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        num_q <= raw_num_i;
        den_q <= (raw_num_i == '0) ? WIDTH'(1) : raw_den_i;
        y_q   <= mag(raw_den_i);
        rem_q <= '0;
        quo_q <= mag(raw_num_i);
        cnt_q <= '0;
      end
      ST_MOD: begin
        if (cnt_q == CW'(WIDTH)) begin
          if (rsub == '0) begin
            g_q   <= y_q;
            rem_q <= '0;
            quo_q <= mn;
          end else begin
            y_q   <= rsub;
            rem_q <= '0;
            quo_q <= y_q;
          end
          cnt_q <= '0;
        end else begin
          rem_q <= rsub;
          quo_q <= qn;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_DIVN, ST_DIVD: begin
        if (cnt_q == CW'(WIDTH)) begin
          if (st_q == ST_DIVN) begin
            num_q <= sgn(num_q[WIDTH-1], qn);
            quo_q <= md;
          end else begin
            den_q <= sgn(den_q[WIDTH-1], qn);
          end
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          rem_q <= rsub;
          quo_q <= qn;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      default: begin end
    endcase
  end

  assign raw_ready_o = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_OUT);
  assign res_num_o   = num_q;
  assign res_den_o   = den_q;

  `include "assert_macros.svh"
  `RAR_ASSERT(a_cnt_bound, cnt_q <= CW'(WIDTH) || st_q == ST_IDLE || st_q == ST_OUT, "count")
  `RAR_ASSERT(a_out_hold, (res_valid_o && !res_ready_i) |=> $stable(res_num_o), "out hold")
  `RAR_ASSERT(a_gcd_nz, (st_q == ST_DIVN) |-> (g_q != '0), "zero gcd")
endmodule

### src/rational_arith_reduce_unit.sv
// Each Euclid step and each exact division is one bit-serial divider pass; worst case
// near 48 passes for WIDTH=32. Items run one at a time in the back end, the front end
// forms the next raw fraction meanwhile (two-entry queue between).
// Reset (rst_ni low, asynchronous) empties the queue and idles both ends.
module rational_arith_reduce_unit import rar_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd
  input  logic [127:0] s_axis_tdata, // a_num, a_den, b_num, b_den
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // res_num, res_den
);
  logic             rv, rr, qv, qr;
  logic [WIDTH-1:0] rn, rd, qn, qd, on, od;
  logic [2*WIDTH-1:0] qdat;

  function automatic logic [FW-1:0] st(input logic [WIDTH-1:0] v);
    logic [WIDTH+FW-1:0] e;
    e = {{FW{v[WIDTH-1]}}, v};
    return e[FW-1:0];
  endfunction

  rar_front #(.WIDTH(WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser),
    .a_num_i(s_axis_tdata[31:0]), .a_den_i(s_axis_tdata[63:32]),
    .b_num_i(s_axis_tdata[95:64]), .b_den_i(s_axis_tdata[127:96]),
    .raw_valid_o(rv), .raw_ready_i(rr), .raw_num_o(rn), .raw_den_o(rd)
  );

  rar_fifo #(.DW(2*WIDTH)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(rv), .wr_ready_o(rr), .wr_data_i({rd, rn}),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qdat)
  );
  assign qn = qdat[WIDTH-1:0];
  assign qd = qdat[2*WIDTH-1:WIDTH];

  rar_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .raw_valid_i(qv), .raw_ready_o(qr), .raw_num_i(qn), .raw_den_i(qd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_num_o(on), .res_den_o(od)
  );

  assign m_axis_tdata = {st(od), st(on)};
endmodule

### verif/rational_arith_reduce_unit_test.sv
// Testbench for rational_arith_reduce_unit: directed table and random requests vs predictor
module rational_arith_reduce_unit_test import rar_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_req_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
  } frac_res_t;

  typedef struct {
    frac_req_t req;
    logic      known;
    frac_res_t res;
  } table_row_t;

  localparam int NUM_RANDOM = 1830;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;
  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;   // cmd
  logic [127:0] s_axis_tdata = '0;   // a_num, a_den, b_num, b_den
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // res_num, res_den

  frac_res_t expected_q[$];
  int        error_cnt = 0;
  bit        quiet_mode = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_taken = 1'b0;
  int        hold_cycles = 0;
  bit        sending_done = 1'b0;

  rational_arith_reduce_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tuser,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #5ns clk_i = ~clk_i;

  function automatic logic [32:0] mag_of(logic [31:0] v);
    return v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic [31:0] div_exact(logic [31:0] v, logic [32:0] d);
    logic [32:0] q;
    q = mag_of(v) / d;
    return v[31] ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic frac_res_t reduce_fraction(frac_req_t r);
    logic [31:0] n, d;
    logic [32:0] x, y, t;
    frac_res_t   o;
    case (r.cmd)
      CMD_ADD: begin
        n = r.a_num * r.b_den + r.b_num * r.a_den;
        d = r.a_den * r.b_den;
      end
      CMD_SUB: begin
        n = r.a_num * r.b_den - r.b_num * r.a_den;
        d = r.a_den * r.b_den;
      end
      CMD_MUL: begin
        n = r.a_num * r.b_num;
        d = r.a_den * r.b_den;
      end
      default: begin
        n = r.a_num * r.b_den;
        d = r.a_den * r.b_num;
      end
    endcase
    if (n == 0) begin
      d = 32'd1;
    end else if (d != 0) begin
      x = mag_of(n);
      y = mag_of(d);
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      n = div_exact(n, x);
      d = div_exact(d, x);
    end
    o.num = n;
    o.den = d;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, $signed(got), $signed(want));
    error_cnt++;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MIN_NEG : MAX_POS;
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(frac_req_t r);
    s_axis_tuser <= r.cmd;
    s_axis_tdata <= {r.b_den, r.b_num, r.a_den, r.a_num};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(reduce_fraction(r));
    @(negedge clk_i);
    if (!quiet_mode && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < 13);
    end
  endtask

  function automatic table_row_t row(logic [1:0] c, logic [31:0] an, logic [31:0] ad,
                                     logic [31:0] bn, logic [31:0] bd,
                                     logic k = 1'b0, logic [31:0] rn = '0,
                                     logic [31:0] rd = '0);
    table_row_t t;
    t.req = '{c, an, ad, bn, bd};
    t.known = k;
    t.res = '{rn, rd};
    return t;
  endfunction

  table_row_t directed[$];

  initial begin
    frac_req_t r;
    directed = '{
      row(CMD_ADD, 1, 2, 1, 2, 1, 1, 1),
      row(CMD_SUB, 1, 2, 1, 2, 1, 0, 1),
      row(CMD_MUL, 2, 3, 3, 4, 1, 1, 2),
      row(CMD_DIV, 2, 3, 4, 9, 1, 3, 2),
      row(CMD_MUL, 5, 0, 7, 3, 1, 35, 0),
      row(CMD_MUL, 0, 0, 7, 3, 1, 0, 1),
      row(CMD_MUL, MIN_NEG, 1, 1, MIN_NEG, 1, 32'hffff_ffff, 32'hffff_ffff),
      row(CMD_MUL, 3, 5, 1, -1, 1, 3, -5),
      row(CMD_ADD, MAX_POS, MAX_POS, MIN_NEG, MIN_NEG),
      row(CMD_SUB, MIN_NEG, MAX_POS, MAX_POS, MIN_NEG),
      row(CMD_MUL, MAX_POS, MAX_POS, MAX_POS, MAX_POS),
      row(CMD_DIV, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG),
      row(CMD_DIV, 32'hffff_ffff, 32'hffff_ffff, 0, 32'hffff_ffff),
      row(CMD_ADD, 0, 0, 0, 0, 1, 0, 1),
      row(CMD_ADD, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff),
      row(CMD_SUB, 65536, 3, 65536, 5),
      row(CMD_DIV, 12, 18, 0, 7, 1, 84, 0)
    };
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].known && expected_q[$] != directed[i].res)
        report_mismatch("table row", expected_q[$].num, directed[i].res.num);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) begin
        hold_req = 1'b1;
      end
      if (i == 700) begin
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk_i);
      end
      quiet_mode = (i >= 1000 && i < 1200);
      r.cmd = 2'($urandom_range(0, 3));
      r.a_num = rand_val();
      r.a_den = rand_val();
      r.b_num = rand_val();
      r.b_den = rand_val();
      send_request(r);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_mode || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    frac_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      got.num = m_axis_tdata[31:0];
      got.den = m_axis_tdata[63:32];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.num, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
        if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
      end
    end
  end

  initial begin
    wait (sending_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("[rational_arith_reduce_unit] OK");
    end else begin
      $display("[rational_arith_reduce_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("[rational_arith_reduce_unit] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/rar_pkg.sv
src/rar_front.sv
src/rar_fifo.sv
src/rar_back.sv
src/rational_arith_reduce_unit.sv
verif/rational_arith_reduce_unit_test.sv
